[hw/rtl/process_deque_with_delete_by_id_macros.svh]
// Assertion macros for the process deque block.
`ifndef PROCESS_DEQUE_WITH_DELETE_BY_ID_MACROS_SVH
`define PROCESS_DEQUE_WITH_DELETE_BY_ID_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define PDQ_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("pdq check failed");

// Check that a condition implies a consequence in the same cycle.
`define PDQ_ASSERT_IMPL(lbl, cond, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error("pdq implication failed");

// Check that a condition implies a consequence in the following cycle.
`define PDQ_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error("pdq next-cycle check failed");

`endif

[hw/rtl/pdq_pkg.sv]
// Command and status codes for the process deque block.
`timescale 1ns / 1ps
package pdq_pkg;

  typedef enum logic [1:0] {
    KIND_PUSH_BACK  = 2'd0,
    KIND_PUSH_FRONT = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_DELETE     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  localparam int unsigned OutIdBits = 16;
  localparam int unsigned InIdBits  = 16;

endpackage

[hw/rtl/process_deque_with_delete_by_id.sv]
// Bounded deque of process identifiers with delete by identifier.
//
// Input channel: in_valid_i / in_stall_o carry one command (kind_i, proc_id_i)
// per transfer: push back, push front, pop front or delete first match.
// Output channel: out_valid_o / out_stall_i carry one result per command:
// status_o, out_id_o (popped identifier, else zero) and count_o.
// Entries sit in a circular buffer in one synchronous RAM (one read, one
// write port), addressed from a head pointer, so pushes and pops need no
// moving of data. Push, empty and full cases go straight to S_FIN; a pop
// passes through S_POP. A delete scans from the front, one entry a cycle
// through the RAM read port, then closes the gap by moving each later
// entry down one place, again one a cycle.
// One command is in work at a time; in_stall_o is high until its result is
// loaded into the output register, and a new command may be taken while that
// result waits. If the receiver stalls, the result is held in the output
// register and a finished next command waits in its final state.
// Reset empties the deque at once (count and head cleared); RAM contents
// are left as they are and never read before being written.
`timescale 1ns / 1ps
module process_deque_with_delete_by_id #(
  parameter int unsigned DEPTH   = 64,
  parameter int unsigned ID_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          kind_i,
  input  logic [pdq_pkg::InIdBits-1:0]        proc_id_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic [pdq_pkg::OutIdBits-1:0]       out_id_o,
  output logic [$clog2(DEPTH+1)-1:0]          count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW+1:0] DepthW = (AW + 2)'(DEPTH);
  localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_SHIFT,
    S_FIN
  } state_e;

  state_e                state_q, state_d;
  logic [AW-1:0]         head_q, head_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic [ID_BITS-1:0]    id_q, id_d;
  logic [ID_BITS-1:0]    res_id_q, res_id_d;
  pdq_pkg::status_e      res_st_q, res_st_d;
  logic                  out_valid_q, out_valid_d;
  logic [1:0]            status_q, status_d;
  logic [pdq_pkg::OutIdBits-1:0] out_id_q, out_id_d;
  logic [CW-1:0]         count_q, count_d;

  logic [ID_BITS-1:0]    mem [DEPTH];
  logic [ID_BITS-1:0]    rdata_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [AW-1:0]         mem_ra;

  logic                  in_acc;
  logic                  out_free;
  logic                  full;
  logic                  empty;
  logic [ID_BITS-1:0]    id_in;
  logic [31:0]           pid_ext;
  logic [31:0]           res_ext;
  logic [AW+1:0]         idx_p1;
  logic [AW+1:0]         idx_p2;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [AW+1:0] b);
    logic [AW+1:0] s;
    s = (AW + 2)'(a) + b;
    if (s >= DepthW) s = s - DepthW;
    return s[AW-1:0];
  endfunction

  assign pid_ext  = 32'(proc_id_i);
  assign id_in    = pid_ext[ID_BITS-1:0];
  assign res_ext  = 32'(res_id_q);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign full     = (cnt_q == DepthC);
  assign empty    = (cnt_q == '0);
  assign idx_p1   = (AW + 2)'(idx_q) + (AW + 2)'(1);
  assign idx_p2   = (AW + 2)'(idx_q) + (AW + 2)'(2);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    id_d        = id_q;
    res_id_d    = res_id_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    out_id_d    = out_id_q;
    count_d     = count_q;
    mem_we      = 1'b0;
    mem_wa      = head_q;
    mem_ra      = head_q;

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          id_d     = id_in;
          res_id_d = '0;
          res_st_d = pdq_pkg::ST_OK;
          idx_d    = '0;
          state_d  = S_FIN;
          unique case (pdq_pkg::kind_e'(kind_i))
            pdq_pkg::KIND_PUSH_BACK: begin
              if (full) begin
                res_st_d = pdq_pkg::ST_FULL;
              end else begin
                mem_we = 1'b1;
                mem_wa = wrap_add(head_q, (AW + 2)'(cnt_q));
                cnt_d  = cnt_q + CW'(1);
              end
            end
            pdq_pkg::KIND_PUSH_FRONT: begin
              if (full) begin
                res_st_d = pdq_pkg::ST_FULL;
              end else begin
                head_d = (head_q == '0) ? LastAddr : head_q - AW'(1);
                mem_we = 1'b1;
                mem_wa = head_d;
                cnt_d  = cnt_q + CW'(1);
              end
            end
            pdq_pkg::KIND_POP_FRONT: begin
              if (empty) res_st_d = pdq_pkg::ST_EMPTY;
              else state_d = S_POP;
            end
            pdq_pkg::KIND_DELETE: begin
              if (empty) res_st_d = pdq_pkg::ST_EMPTY;
              else state_d = S_SCAN;
            end
            default: res_st_d = pdq_pkg::ST_OK;
          endcase
        end
      end
      S_POP: begin
        res_id_d = rdata_q;
        head_d   = wrap_add(head_q, (AW + 2)'(1));
        cnt_d    = cnt_q - CW'(1);
        state_d  = S_FIN;
      end
      S_SCAN: begin
        // rdata_q holds the entry at logical index idx_q
        if (rdata_q == id_q) begin
          if (idx_p1 == (AW + 2)'(cnt_q)) begin
            cnt_d   = cnt_q - CW'(1);
            state_d = S_FIN;
          end else begin
            mem_ra  = wrap_add(head_q, idx_p1);
            state_d = S_SHIFT;
          end
        end else if (idx_p1 == (AW + 2)'(cnt_q)) begin
          res_st_d = pdq_pkg::ST_NOT_FOUND;
          state_d  = S_FIN;
        end else begin
          idx_d  = idx_p1[AW-1:0];
          mem_ra = wrap_add(head_q, idx_p1);
        end
      end
      S_SHIFT: begin
        // move entry idx_q+1 down into idx_q, fetch the next one
        mem_we = 1'b1;
        mem_wa = wrap_add(head_q, (AW + 2)'(idx_q));
        idx_d  = idx_p1[AW-1:0];
        if (idx_p2 == (AW + 2)'(cnt_q)) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_FIN;
        end else begin
          mem_ra = wrap_add(head_q, idx_p2);
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = res_st_q;
          out_id_d    = res_ext[pdq_pkg::OutIdBits-1:0];
          count_d     = cnt_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    id_q     <= id_d;
    res_id_q <= res_id_d;
    res_st_q <= res_st_d;
    status_q <= status_d;
    out_id_q <= out_id_d;
    count_q  <= count_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= (state_q == S_SHIFT) ? rdata_q : id_d;
    rdata_q <= mem[mem_ra];
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_id_o    = out_id_q;
  assign count_o     = count_q;

`include "process_deque_with_delete_by_id_macros.svh"

  `PDQ_ASSERT(a_cnt_bound, cnt_q <= DepthC)
  `PDQ_ASSERT_IMPL(a_id_only_ok, out_valid_o && status_o != pdq_pkg::ST_OK, out_id_o == '0)
  `PDQ_ASSERT_NEXT(a_pop_shrinks, state_q == S_POP, cnt_q == $past(cnt_q) - CW'(1))
  `PDQ_ASSERT_IMPL(a_shift_in_range, state_q == S_SHIFT, idx_p1 < (AW + 2)'(cnt_q))

endmodule

[tb/sv/process_deque_with_delete_by_id_tb.sv]
// Self-checking testbench for the process identifier deque with delete by identifier.
`timescale 1ns / 1ps
module process_deque_with_delete_by_id_tb;

  localparam int unsigned Depth = 64;
  localparam int unsigned RandItems = 1400;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [6:0]  count;
  } result_t;

  typedef struct {
    pdq_pkg::kind_e   kind;
    logic [15:0]      id;
    logic             has_exp;
    pdq_pkg::status_e status;
    logic [6:0]       count;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  kind_i = pdq_pkg::KIND_PUSH_BACK;
  logic [15:0] proc_id_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [15:0] out_id_o;
  logic [6:0]  count_o;

  process_deque_with_delete_by_id uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state: identifiers held, front first
  logic [15:0] held_ids[$];
  result_t     pending_results[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          n_sent = 0;
  int          n_got = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          timed_out = 0;

  function automatic result_t apply_command(pdq_pkg::kind_e kind, logic [15:0] id);
    result_t r;
    r = '0;
    r.status = pdq_pkg::ST_OK;
    case (kind) inside
      pdq_pkg::KIND_PUSH_BACK, pdq_pkg::KIND_PUSH_FRONT: begin
        if (held_ids.size() >= Depth) r.status = pdq_pkg::ST_FULL;
        else if (kind == pdq_pkg::KIND_PUSH_BACK) held_ids.push_back(id);
        else held_ids.push_front(id);
      end
      pdq_pkg::KIND_POP_FRONT: begin
        if (held_ids.size() == 0) r.status = pdq_pkg::ST_EMPTY;
        else r.out_id = held_ids.pop_front();
      end
      default: begin
        if (held_ids.size() == 0) r.status = pdq_pkg::ST_EMPTY;
        else begin
          r.status = pdq_pkg::ST_NOT_FOUND;
          foreach (held_ids[i]) begin
            if (held_ids[i] == id) begin
              held_ids.delete(i);
              r.status = pdq_pkg::ST_OK;
              break;
            end
          end
        end
      end
    endcase
    r.count = 7'(held_ids.size());
    return r;
  endfunction

  // check results and watch for a hang
  always @(posedge clk_i) begin
    result_t got, exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {status_o, out_id_o, count_o};
      n_got++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        exp = pending_results.pop_front();
        if (got !== exp) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d id=%h cnt=%0d got st=%0d id=%h cnt=%0d",
                     exp.status, exp.out_id, exp.count, got.status, got.out_id, got.count);
        end
      end
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit && !timed_out) begin
      timed_out = 1;
      $display("watchdog expired");
      $display("process_deque_with_delete_by_id_tb: FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  task automatic send_command(pdq_pkg::kind_e kind, logic [15:0] id, output result_t exp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    proc_id_i <= id;
    do @(posedge clk_i); while (in_stall_o);
    exp = apply_command(kind, id);
    pending_results.push_back(exp);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_id();
    // reuse held identifiers often so deletes hit and duplicates arise
    if (held_ids.size() != 0 && $urandom_range(2) != 0)
      return held_ids[$urandom_range(held_ids.size() - 1)];
    if ($urandom_range(1)) return 16'($urandom_range(7));
    return 16'($urandom);
  endfunction

  row_t           rows[$];
  result_t        exp;
  pdq_pkg::kind_e k;
  int             fill_bias;

  initial begin
    // directed table: empty cases, extremes, duplicates
    rows.push_back('{pdq_pkg::KIND_POP_FRONT,  16'h0000, 1, pdq_pkg::ST_EMPTY,     7'd0});
    rows.push_back('{pdq_pkg::KIND_DELETE,     16'h1234, 1, pdq_pkg::ST_EMPTY,     7'd0});
    rows.push_back('{pdq_pkg::KIND_PUSH_BACK,  16'hFFFF, 1, pdq_pkg::ST_OK,        7'd1});
    rows.push_back('{pdq_pkg::KIND_PUSH_FRONT, 16'h0000, 1, pdq_pkg::ST_OK,        7'd2});
    rows.push_back('{pdq_pkg::KIND_PUSH_BACK,  16'hFFFF, 1, pdq_pkg::ST_OK,        7'd3});
    rows.push_back('{pdq_pkg::KIND_DELETE,     16'hAAAA, 1, pdq_pkg::ST_NOT_FOUND, 7'd3});
    rows.push_back('{pdq_pkg::KIND_DELETE,     16'hFFFF, 0, pdq_pkg::ST_OK,        7'd0});
    rows.push_back('{pdq_pkg::KIND_POP_FRONT,  16'h5555, 0, pdq_pkg::ST_OK,        7'd0});
    rows.push_back('{pdq_pkg::KIND_DELETE,     16'hFFFF, 0, pdq_pkg::ST_OK,        7'd0});
    rows.push_back('{pdq_pkg::KIND_PUSH_FRONT, 16'h5555, 0, pdq_pkg::ST_OK,        7'd0});
    rows.push_back('{pdq_pkg::KIND_POP_FRONT,  16'h0000, 0, pdq_pkg::ST_OK,        7'd0});
    rows.push_back('{pdq_pkg::KIND_POP_FRONT,  16'h0000, 1, pdq_pkg::ST_EMPTY,     7'd0});

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      send_command(rows[i].kind, rows[i].id, exp);
      if (rows[i].has_exp && (exp.status != rows[i].status || exp.count != rows[i].count)) begin
        mismatches++;
        if (mismatches <= 10) $display("directed row %0d disagrees with predictor", i);
      end
    end
    // fill to full, push both ways when full, then delete the back and front entries
    for (int i = 0; i < Depth; i++) send_command(pdq_pkg::KIND_PUSH_BACK, 16'(i * 1031), exp);
    send_command(pdq_pkg::KIND_PUSH_BACK, 16'hBEEF, exp);
    send_command(pdq_pkg::KIND_PUSH_FRONT, 16'hBEEF, exp);
    send_command(pdq_pkg::KIND_DELETE, 16'((Depth - 1) * 1031), exp);
    send_command(pdq_pkg::KIND_DELETE, 16'h0000, exp);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 86; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 86; end
        default: begin send_idle_pct = 7; stall_pct = 7; end
      endcase
      for (int i = 0; i < RandItems / 4; i++) begin
        // swing occupancy between empty and full
        fill_bias = ((i / 60) % 2 == 0) ? 70 : 25;
        if ($urandom_range(99) < fill_bias)
          k = $urandom_range(1) ? pdq_pkg::KIND_PUSH_BACK : pdq_pkg::KIND_PUSH_FRONT;
        else
          k = $urandom_range(1) ? pdq_pkg::KIND_POP_FRONT : pdq_pkg::KIND_DELETE;
        send_command(k, pick_id(), exp);
        if (i == 100) drain();
      end
      drain();
    end

    stall_pct = 0;
    drain();
    repeat (Depth * 3) @(negedge clk_i);
    $display("ran %0d commands, %0d results checked, occupancy swept from empty to full",
             n_sent, n_got);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("process_deque_with_delete_by_id_tb: PASS");
    else
      $display("process_deque_with_delete_by_id_tb: FAIL");
    $finish;
  end
endmodule
